[rtl/core/dvru_pkg.sv]
// Shared constants, codes and controller/datapath types of the route update unit.
package dvru_pkg;

  // Table geometry and field widths.
  localparam int NODES     = 16;
  localparam int COST_BITS = 16;
  localparam int IDX_W     = $clog2(NODES);
  localparam int NODE_W    = 4;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int SIL_W     = 4;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [COST_BITS-1:0] COST_INF          = '1;
  localparam logic [SIL_W-1:0]     SILENCE_MAX       = '1;
  localparam logic [SIL_W-1:0]     SILENCE_LIMIT_RST = 4'd3;
  localparam logic [NODE_W-1:0]    SELF_ID_RST       = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 1'b1;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    REQ_LOAD    = 3'd0,
    REQ_ADVERT  = 3'd1,
    REQ_SET     = 3'd2,
    REQ_DISABLE = 3'd3,
    REQ_RESET   = 3'd4,
    REQ_TICK    = 3'd5,
    REQ_LOOKUP  = 3'd6
  } req_kind_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NOT_NB  = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_QUIET,
    OP_LU_START,
    OP_LU_STEP,
    OP_LU_END,
    OP_ADV,
    OP_CLEAR,
    OP_TICK_STEP,
    OP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    st_we;
    status_t st_val;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      node_in;
    logic      node_ok;
    logic      target_ok;
    logic      mark;
    logic      rn_inf;
    logic      tgt_self;
    logic      rn_ne_cost;
    logic      tick_dis;
    logic      a_last;
    logic      j_last;
    logic      lu_tick;
    logic      out_hold;
  } dp_stat_t;

endpackage

[rtl/core/dvru_ifs.sv]
// Request and result channel interfaces of the route update unit.
interface dvru_req_if;
  import dvru_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    req_type;
  logic [NODE_W-1:0]    node;
  logic [NODE_W-1:0]    target;
  logic [COST_BITS-1:0] cost_in;
  modport source (output valid, req_type, node, target, cost_in, input ready);
  modport sink (input valid, req_type, node, target, cost_in, output ready);
endinterface

interface dvru_rsp_if;
  import dvru_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [COST_BITS-1:0] route_cost_out;
  logic [NODE_W-1:0]    next_hop_out;
  modport source (output valid, status, route_cost_out, next_hop_out, input ready);
  modport sink (input valid, status, route_cost_out, next_hop_out, output ready);
endinterface

[rtl/core/dvru_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module dvru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dvru_pkg::dp_stat_t stat,
  output dvru_pkg::dp_cmd_t  cmd
);
  import dvru_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LU_BEGIN,
    S_LU_SWEEP,
    S_LU_END,
    S_ADV,
    S_TICK,
    S_REPORT
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.st_we  = 1'b0;
    cmd.st_val = ST_DONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_REPORT;
        case (stat.kind)
          REQ_LOAD: begin
            if (!stat.node_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end else begin
              cmd.op = OP_LOAD;
            end
          end
          REQ_ADVERT: begin
            if (!stat.node_ok || !stat.target_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end else if (!stat.mark) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_NOT_NB;
            end else if (stat.rn_inf) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_IGNORED;
            end else begin
              cmd.op = OP_QUIET;
              if (!stat.tgt_self) begin
                state_next = S_ADV;
              end else if (stat.rn_ne_cost) begin
                state_next = S_LU_BEGIN;
              end
            end
          end
          REQ_SET: begin
            if (!stat.node_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end else begin
              cmd.op     = OP_LU_START;
              state_next = S_LU_SWEEP;
            end
          end
          REQ_DISABLE: begin
            if (!stat.node_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end else if (!stat.mark) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_NOT_NB;
            end else begin
              cmd.op     = OP_LU_START;
              state_next = S_LU_SWEEP;
            end
          end
          REQ_RESET: begin
            cmd.op = OP_CLEAR;
          end
          REQ_TICK: begin
            state_next = S_TICK;
          end
          REQ_LOOKUP: begin
            if (!stat.node_in) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end
          end
          default: begin
            state_next = S_REPORT;
          end
        endcase
      end
      S_LU_BEGIN: begin
        cmd.op     = OP_LU_START;
        state_next = S_LU_SWEEP;
      end
      S_LU_SWEEP: begin
        cmd.op = OP_LU_STEP;
        if (stat.j_last) begin
          state_next = S_LU_END;
        end
      end
      S_LU_END: begin
        cmd.op = OP_LU_END;
        if (stat.lu_tick && !stat.a_last) begin
          state_next = S_TICK;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_ADV: begin
        cmd.op     = OP_ADV;
        state_next = S_REPORT;
      end
      S_TICK: begin
        cmd.op = OP_TICK_STEP;
        if (stat.tick_dis) begin
          state_next = S_LU_SWEEP;
        end else if (stat.a_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!stat.out_hold) begin
          cmd.op     = OP_REPORT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/dvru_dp.sv]
// Datapath: route tables, link and neighbor state, sweep counters and result register.
module dvru_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dvru_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [dvru_pkg::CFG_W-1:0]     cfg_data,
  input  logic [dvru_pkg::KIND_W-1:0]    req_type,
  input  logic [dvru_pkg::NODE_W-1:0]    node,
  input  logic [dvru_pkg::NODE_W-1:0]    target,
  input  logic [dvru_pkg::COST_BITS-1:0] cost_in,
  input  dvru_pkg::dp_cmd_t              cmd,
  output dvru_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dvru_pkg::STAT_W-1:0]    status,
  output logic [dvru_pkg::COST_BITS-1:0] route_cost_out,
  output logic [dvru_pkg::NODE_W-1:0]    next_hop_out
);
  import dvru_pkg::*;

  // Per-node tables.
  logic [COST_BITS-1:0] route_cost     [NODES];
  logic [IDX_W-1:0]     route_next_hop [NODES];
  logic [COST_BITS-1:0] direct_cost    [NODES];
  logic                 neighbor_mark  [NODES];
  logic [SIL_W-1:0]     silence_count  [NODES];

  // Configuration and latched item.
  logic [NODE_W-1:0]    self_id;
  logic [SIL_W-1:0]     silence_limit;
  req_kind_t            kind;
  logic [NODE_W-1:0]    node_r;
  logic [NODE_W-1:0]    target_r;
  logic [COST_BITS-1:0] cost_r;
  status_t              status_r;

  // Link update and tick sequencing.
  logic [COST_BITS-1:0] rn;
  logic [IDX_W-1:0]     lu_node;
  logic                 lu_dis;
  logic                 lu_tick;
  logic [IDX_W-1:0]     j;
  logic [IDX_W-1:0]     a;

  logic [NODE_W-1:0]    rep;
  logic                 rep_in;
  logic [IDX_W-1:0]     node_i;
  logic [IDX_W-1:0]     addr;
  logic [COST_BITS-1:0] rd_cost;
  logic [IDX_W-1:0]     rd_nh;
  logic [COST_BITS-1:0] rd_dir;
  logic                 rd_mark;
  logic [SIL_W-1:0]     rd_sil;
  logic [SIL_W-1:0]     sil_next;
  logic [COST_BITS:0]   sum_wide;
  logic [COST_BITS-1:0] sum;

  assign node_i = node_r[IDX_W-1:0];
  assign rep    = (kind == REQ_ADVERT) ? target_r : node_r;
  assign rep_in = (32'(rep) < NODES);

  // One table address per cycle, chosen by the current operation.
  always_comb begin
    case (cmd.op)
      OP_LU_STEP:   addr = j;
      OP_LU_END:    addr = lu_node;
      OP_TICK_STEP: addr = a;
      OP_ADV:       addr = target_r[IDX_W-1:0];
      OP_REPORT:    addr = rep[IDX_W-1:0];
      default:      addr = node_i;
    endcase
  end

  assign rd_cost = route_cost[addr];
  assign rd_nh   = route_next_hop[addr];
  assign rd_dir  = direct_cost[addr];
  assign rd_mark = neighbor_mark[addr];
  assign rd_sil  = silence_count[addr];

  // Silence counter step and saturating advert sum.
  assign sil_next = (rd_sil == SILENCE_MAX) ? rd_sil : rd_sil + 1'b1;
  assign sum_wide = {1'b0, rn} + {1'b0, cost_r};
  assign sum      = sum_wide[COST_BITS] ? COST_INF : sum_wide[COST_BITS-1:0];

  // Status toward the controller.
  always_comb begin
    stat.kind       = kind;
    stat.node_in    = (32'(node_r) < NODES);
    stat.node_ok    = (32'(node_r) < NODES) && (node_r != self_id);
    stat.target_ok  = (32'(target_r) < NODES);
    stat.mark       = rd_mark;
    stat.rn_inf     = (rd_cost == COST_INF);
    stat.tgt_self   = (target_r == self_id);
    stat.rn_ne_cost = (rd_cost != cost_r);
    stat.tick_dis   = (sil_next > silence_limit) && rd_mark &&
                      (NODE_W'(a) != self_id) && (rd_cost != COST_INF);
    stat.a_last     = (32'(a) == NODES - 1);
    stat.j_last     = (32'(j) == NODES - 1);
    stat.lu_tick    = lu_tick;
    stat.out_hold   = out_valid && !out_ready;
  end

  // Tables, sequencing registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        route_cost[i]     <= COST_INF;
        route_next_hop[i] <= IDX_W'(i);
        direct_cost[i]    <= COST_INF;
        neighbor_mark[i]  <= 1'b0;
        silence_count[i]  <= '0;
      end
      self_id       <= SELF_ID_RST;
      silence_limit <= SILENCE_LIMIT_RST;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SELF_ID:       self_id       <= cfg_data;
          CFG_SILENCE_LIMIT: silence_limit <= cfg_data;
          default: ;
        endcase
      end
      // A new result replaces one that is taken in the same cycle.
      if (cmd.op == OP_REPORT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.st_we) begin
        status_r <= cmd.st_val;
      end
      case (cmd.op)
        OP_LATCH: begin
          kind     <= req_kind_t'(req_type);
          node_r   <= node;
          target_r <= target;
          cost_r   <= cost_in;
          status_r <= ST_DONE;
          a        <= '0;
        end
        OP_LOAD: begin
          neighbor_mark[addr]  <= 1'b1;
          direct_cost[addr]    <= cost_r;
          route_cost[addr]     <= cost_r;
          route_next_hop[addr] <= addr;
        end
        OP_QUIET: begin
          silence_count[addr] <= '0;
          rn                  <= rd_cost;
        end
        OP_LU_START: begin
          lu_node <= addr;
          lu_dis  <= (kind == REQ_DISABLE);
          lu_tick <= 1'b0;
          j       <= '0;
          route_cost[addr]     <= (kind == REQ_DISABLE) ? COST_INF : cost_r;
          route_next_hop[addr] <= addr;
        end
        OP_TICK_STEP: begin
          silence_count[addr] <= sil_next;
          if (stat.tick_dis) begin
            lu_node              <= addr;
            lu_dis               <= 1'b1;
            lu_tick              <= 1'b1;
            j                    <= '0;
            route_cost[addr]     <= COST_INF;
            route_next_hop[addr] <= addr;
          end else begin
            a <= a + 1'b1;
          end
        end
        OP_LU_STEP: begin
          // Routes that went through the changed link fall back to the direct link.
          if (addr != lu_node && rd_nh == lu_node) begin
            route_cost[addr]     <= rd_dir;
            route_next_hop[addr] <= addr;
          end
          j <= j + 1'b1;
        end
        OP_LU_END: begin
          if (lu_dis) begin
            direct_cost[addr] <= COST_INF;
          end
          if (lu_tick) begin
            a <= a + 1'b1;
          end
        end
        OP_ADV: begin
          // Relax the target route via the neighbor, or revert to the direct link.
          if (sum < rd_cost) begin
            route_cost[addr]     <= sum;
            route_next_hop[addr] <= node_i;
          end else if (sum > rd_cost && rd_nh == node_i) begin
            route_cost[addr]     <= rd_dir;
            route_next_hop[addr] <= addr;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NODES; i++) begin
            route_cost[i]     <= COST_INF;
            route_next_hop[i] <= IDX_W'(i);
          end
        end
        OP_REPORT: begin
          status    <= status_r;
          if (!rep_in) begin
            route_cost_out <= COST_INF;
            next_hop_out   <= '0;
          end else if (rep == self_id) begin
            route_cost_out <= '0;
            next_hop_out   <= self_id;
          end else begin
            route_cost_out <= rd_cost;
            next_hop_out   <= NODE_W'(rd_nh);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/distance_vector_route_update_unit.sv]
// Top level of the distance-vector route update unit.
//
//   channel  dir  transfer           contents
//   req      in   valid && ready     req_type, node, target, cost_in
//   rsp      out  valid && ready     status, route_cost_out, next_hop_out
//   cfg      in   cfg_we             cfg_idx selects self_id or silence_limit
//
// One item at a time. Load, lookup, reset routes, out-of-range and refused
// items go from check to report, an advert through the advert state (the
// link update sweep when it is about this node and changes the link), set
// link or disable through that sweep, one entry per cycle. A tick visits
// every node, sweeping for each neighbor it disables. Reset is synchronous
// and leaves all tables at their reset values at once. A result waits in
// the output register while the next item is already accepted.
module distance_vector_route_update_unit (
  input  logic                           clk,
  input  logic                           rst,
  dvru_req_if.sink                       req,
  dvru_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [dvru_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [dvru_pkg::CFG_W-1:0]     cfg_data
);
  import dvru_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  dvru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables and result register.
  dvru_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .req_type       (req.req_type),
    .node           (req.node),
    .target         (req.target),
    .cost_in        (req.cost_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .route_cost_out (rsp.route_cost_out),
    .next_hop_out   (rsp.next_hop_out)
  );

  // An accepted item keeps the request side closed for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item was in progress");

  // No result is pending right after reset.
  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result valid after reset");

  // A waiting result stays valid and unchanged until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) &&
      $stable(rsp.route_cost_out) && $stable(rsp.next_hop_out))
    else $error("waiting result dropped or changed");

endmodule
